### rtl/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared constants, payload types and controller/datapath interface structs
// for the fixed-point 4x4 matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;

  localparam int CELLS  = DIM * DIM;
  localparam int DIM_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int CELL_W = $clog2(CELLS);
  localparam int STEP_W = $clog2(DIM + 3);
  localparam int PROD_W = 64;
  localparam int ACC_W  = PROD_W + $clog2(DIM);

  typedef struct packed {
    logic signed [31:0] a_element;
    logic signed [31:0] b_element;
  } mm4_in_t;

  typedef struct packed {
    logic signed [31:0] product_element;
    logic [1:0]         out_row;
    logic [1:0]         out_column;
    logic               last_of_run;
  } mm4_out_t;

  typedef struct packed {
    logic              wr_en;
    logic [CELL_W-1:0] wr_addr;
    logic              rd_en;
    logic              rd_first;
    logic [CELL_W-1:0] rd_a_addr;
    logic [CELL_W-1:0] rd_b_addr;
    logic              fin;
    logic [DIM_W-1:0]  fin_row;
    logic [DIM_W-1:0]  fin_col;
    logic              fin_last;
  } mm4_cmd_t;

  typedef struct packed {
    logic out_free;
  } mm4_sts_t;

endpackage

### rtl/matrix_multiply_4x4.sv
// ----------------------------------------------------------------------------
// matrix_multiply_4x4
// Fixed-point C = A * B on DIM x DIM matrices, column-major, Q16.16.
// ----------------------------------------------------------------------------
// Load 16 beats, one pair (A, B element) per cycle, in column-major order;
// the block stalls input after the sixteenth beat and emits the 16 elements
// of C in column-major order, last_of_run set on the final one. Each output
// element takes four multiply-accumulate steps through the single 32x32
// multiplier behind the registered store reads, pipeline fill, and a
// round/saturate step, plus any output stall. Sums are exact, rounded half
// toward plus infinity and saturated to 32 bits. Input reopens once the last
// element is in the output register.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4 import mm4_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mm4_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output mm4_out_t out_data_o
);

  mm4_cmd_t cmd;
  mm4_sts_t sts;

  mm4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mm4_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/mm4_ctrl.sv
// ----------------------------------------------------------------------------
// mm4_ctrl
// Sequencer: counts loaded beats, then walks every product element through
// DIM multiply-accumulate steps and a round/saturate/emit step.
// ----------------------------------------------------------------------------
module mm4_ctrl import mm4_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mm4_sts_t sts_i,
  output mm4_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_CALC,
    S_FIN
  } state_e;

  localparam logic [CELL_W-1:0] DIM_C    = CELL_W'(DIM);
  localparam logic [CELL_W-1:0] CNT_LAST = CELL_W'(CELLS - 1);
  localparam logic [DIM_W-1:0]  IDX_LAST = DIM_W'(DIM - 1);
  localparam logic [STEP_W-1:0] STEP_RD  = STEP_W'(DIM);
  localparam logic [STEP_W-1:0] STEP_END = STEP_W'(DIM + 1);

  state_e            state_q;
  logic [CELL_W-1:0] cnt_q;
  logic [STEP_W-1:0] step_q;
  logic [DIM_W-1:0]  row_q;
  logic [DIM_W-1:0]  col_q;
  logic [DIM_W-1:0]  k;
  logic              last_elem;

  assign k          = step_q[DIM_W-1:0];
  assign last_elem  = (row_q == IDX_LAST) && (col_q == IDX_LAST);
  assign in_stall_o = (state_q != S_LOAD);

  always_comb begin
    cmd_o           = '0;
    cmd_o.wr_addr   = cnt_q;
    cmd_o.rd_a_addr = CELL_W'(row_q) + DIM_C * CELL_W'(k);
    cmd_o.rd_b_addr = CELL_W'(k) + DIM_C * CELL_W'(col_q);
    cmd_o.rd_first  = (step_q == '0);
    cmd_o.fin_row   = row_q;
    cmd_o.fin_col   = col_q;
    cmd_o.fin_last  = last_elem;
    case (state_q)
      S_LOAD:  cmd_o.wr_en = in_valid_i;
      S_CALC:  cmd_o.rd_en = (step_q < STEP_RD);
      S_FIN:   cmd_o.fin   = sts_i.out_free;
      default: cmd_o       = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      step_q  <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (in_valid_i) begin
            if (cnt_q == CNT_LAST) begin
              cnt_q   <= '0;
              step_q  <= '0;
              row_q   <= '0;
              col_q   <= '0;
              state_q <= S_CALC;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        S_CALC: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_END) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (sts_i.out_free) begin
            step_q <= '0;
            if (last_elem) begin
              state_q <= S_LOAD;
            end else begin
              state_q <= S_CALC;
              if (row_q == IDX_LAST) begin
                row_q <= '0;
                col_q <= col_q + 1'b1;
              end else begin
                row_q <= row_q + 1'b1;
              end
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

endmodule

### rtl/mm4_datapath.sv
// ----------------------------------------------------------------------------
// mm4_datapath
// Element stores for A and B, registered reads, one 32x32 multiplier,
// wide accumulator, round/saturate and the output register.
// ----------------------------------------------------------------------------
module mm4_datapath import mm4_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mm4_in_t  in_data_i,
  input  mm4_cmd_t cmd_i,
  output mm4_sts_t sts_o,
  input  logic     out_stall_i,
  output logic     out_valid_o,
  output mm4_out_t out_data_o
);

  localparam logic signed [ACC_W:0] HALF   = (ACC_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W:0] SAT_HI = {{(ACC_W - 31){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [ACC_W:0] SAT_LO = {{(ACC_W - 31){1'b1}}, 32'h8000_0000};

  logic [31:0] a_mem [CELLS];
  logic [31:0] b_mem [CELLS];

  logic signed [31:0]     a_rd_q;
  logic signed [31:0]     b_rd_q;
  logic                   rdv_q;
  logic                   rdf_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                   prv_q;
  logic                   prf_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W:0]  rnd;
  logic signed [ACC_W:0]  shifted;
  logic signed [31:0]     sat;
  logic                   out_valid_q;
  mm4_out_t               out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      a_mem[cmd_i.wr_addr] <= in_data_i.a_element;
      b_mem[cmd_i.wr_addr] <= in_data_i.b_element;
    end
    if (cmd_i.rd_en) begin
      a_rd_q <= a_mem[cmd_i.rd_a_addr];
      b_rd_q <= b_mem[cmd_i.rd_b_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q <= 1'b0;
      rdf_q <= 1'b0;
      prv_q <= 1'b0;
      prf_q <= 1'b0;
    end else begin
      rdv_q <= cmd_i.rd_en;
      rdf_q <= cmd_i.rd_first;
      prv_q <= rdv_q;
      prf_q <= rdf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdv_q) begin
      prod_q <= a_rd_q * b_rd_q;
    end
  end

  assign prod_ext = ACC_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (prv_q) begin
      acc_q <= prf_q ? prod_ext : acc_q + prod_ext;
    end
  end

  always_comb begin
    rnd     = $signed({acc_q[ACC_W-1], acc_q}) + HALF;
    shifted = rnd >>> FRAC_BITS;
    if (shifted > SAT_HI) begin
      sat = 32'sh7FFF_FFFF;
    end else if (shifted < SAT_LO) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = shifted[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_q.product_element <= sat;
      out_q.out_row         <= 2'(cmd_i.fin_row);
      out_q.out_column      <= 2'(cmd_i.fin_col);
      out_q.last_of_run     <= cmd_i.fin_last;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

### rtl/mm4_checker.sv
// ----------------------------------------------------------------------------
// mm4_checker
// Port-level checks for matrix_multiply_4x4, bound to the top level.
// ----------------------------------------------------------------------------
module mm4_checker import mm4_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input mm4_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input mm4_out_t out_data_o
);

  localparam logic [1:0] LAST_IDX = 2'(DIM - 1);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input beat changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  a_new_beat_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output beat appeared while loading");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_of_run |->
      (out_data_o.out_row == LAST_IDX) && (out_data_o.out_column == LAST_IDX))
    else $error("last beat not at final element");

  a_last_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o && out_data_o.last_of_run)
    else $error("input reopened without last beat");

endmodule

bind matrix_multiply_4x4 mm4_checker u_mm4_checker (.*);
